/* design/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for stream find-and-replace
// Command format between the front and the back, register indexes and
// length clamping.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned MaxLen    = 8;
  localparam int unsigned LenW      = $clog2(MaxLen + 1);
  localparam int unsigned IdxW      = $clog2(MaxLen);
  localparam int unsigned CountW    = 16;
  localparam int unsigned CmdDepth  = 4;
  localparam int unsigned CmdPtrW   = $clog2(CmdDepth);
  localparam int unsigned CmdCntW   = $clog2(CmdDepth + 1);

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // configuration register indexes
  localparam logic [1:0] CfgPatBytes = 2'd0;
  localparam logic [1:0] CfgPatLen   = 2'd1;
  localparam logic [1:0] CfgRepBytes = 2'd2;
  localparam logic [1:0] CfgRepLen   = 2'd3;

  // one command: data bytes to send in order, then optionally the end beat
  typedef struct packed {
    logic [8*MaxLen-1:0] data;
    logic [LenW-1:0]     n;
    logic                is_end;
    logic [CountW-1:0]   total;
  } cmd_t;

  // clamp a 4-bit length register to [minv, MaxLen]
  function automatic logic [LenW-1:0] eff_len(logic [3:0] v, logic [3:0] minv);
    logic [3:0] r;
    r = v;
    if (r < minv) r = minv;
    if (r > 4'(MaxLen)) r = 4'(MaxLen);
    return LenW'(r);
  endfunction

endpackage

/* design/sfr_front.sv */
// ----------------------------------------------------------------------------
// sfr_front: window update and match classification
// Takes one text beat per cycle while accept_i is high, updates the sliding
// window and turns the step into at most one command for the back end.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                text_end_i,
  input  logic                clear_i,
  input  logic [8*MaxLen-1:0] pat_bytes_i,
  input  logic [LenW-1:0]     pat_len_i,
  input  logic [8*MaxLen-1:0] rep_bytes_i,
  input  logic [LenW-1:0]     rep_len_i,
  output logic                cmd_push_o,
  output cmd_t                cmd_o
);

  logic [7:0]        win_q [MaxLen];
  logic [7:0]        win_d [MaxLen];
  logic [7:0]        wn    [MaxLen];
  logic [IdxW-1:0]   fill_q, fill_d, f;
  logic [CountW-1:0] count_q, count_d, cnt_inc;
  logic [LenW-1:0]   nf;
  logic              full, hit;

  always_comb begin
    f = ({1'b0, fill_q} >= pat_len_i) ? '0 : fill_q;
    for (int i = 0; i < MaxLen; i++) begin
      wn[i] = (IdxW'(i) == f) ? in_byte_i : win_q[i];
    end
    nf   = LenW'(f) + LenW'(1);
    full = (nf == pat_len_i);
    hit  = 1'b1;
    for (int i = 0; i < MaxLen; i++) begin
      if ((LenW'(i) < pat_len_i) && (wn[i] != pat_bytes_i[8*i +: 8])) hit = 1'b0;
    end
    cnt_inc = (count_q == CountMax) ? count_q : count_q + CountW'(1);

    for (int i = 0; i < MaxLen; i++) begin
      cmd_o.data[8*i +: 8] = wn[i];
    end
    cmd_o.n      = '0;
    cmd_o.is_end = text_end_i;
    cmd_o.total  = count_q;
    win_d        = wn;
    fill_d       = nf[IdxW-1:0];
    count_d      = count_q;

    if (full && hit) begin
      cmd_o.data  = rep_bytes_i;
      cmd_o.n     = rep_len_i;
      cmd_o.total = cnt_inc;
      fill_d      = '0;
      count_d     = cnt_inc;
    end else if (full) begin
      // send oldest byte; on the final beat send the whole window
      cmd_o.n = text_end_i ? pat_len_i : LenW'(1);
      fill_d  = IdxW'(pat_len_i - LenW'(1));
      for (int i = 0; i < MaxLen - 1; i++) begin
        win_d[i] = wn[i+1];
      end
      win_d[MaxLen-1] = wn[MaxLen-1];
    end else begin
      cmd_o.n = text_end_i ? nf : '0;
    end

    if (text_end_i) begin
      fill_d  = '0;
      count_d = '0;
    end

    cmd_push_o = accept_i && ((cmd_o.n != '0) || text_end_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
    end else if (clear_i) begin
      fill_q  <= '0;
    end else if (accept_i) begin
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule

/* design/sfr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// sfr_cmd_fifo: command queue between front and back
// Small register queue; full and valid come straight from the fill count.
// ----------------------------------------------------------------------------
module sfr_cmd_fifo import sfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wptr_q, rptr_q;
  logic [CmdCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + CmdPtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + CmdPtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CmdCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CmdCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

/* design/sfr_back.sv */
// ----------------------------------------------------------------------------
// sfr_back: command expansion into result beats
// Walks head command one beat per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  cmd_t              head_i,
  output logic              head_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_byte_o,
  output logic              byte_present_o,
  output logic              run_last_o,
  output logic              text_done_o,
  output logic [CountW-1:0] replace_total_o
);

  logic [LenW-1:0]   k_q;
  logic              oval_q;
  logic              in_data, b_last, adv;
  logic [7:0]        b_byte;
  logic [CountW-1:0] b_total;

  always_comb begin
    in_data = (k_q < head_i.n);
    b_byte  = in_data ? head_i.data[8*k_q[IdxW-1:0] +: 8] : 8'h00;
    b_total = in_data ? '0 : head_i.total;
    b_last  = in_data ? ((k_q == head_i.n - LenW'(1)) && !head_i.is_end) : 1'b1;
    adv     = head_valid_i && (!oval_q || pop_i);
    head_pop_o = adv && b_last;
  end

  assign empty_o = !oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      oval_q <= 1'b0;
    end else begin
      if (!oval_q || pop_i) oval_q <= head_valid_i;
      if (adv) k_q <= b_last ? '0 : k_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_o      <= b_byte;
      byte_present_o  <= in_data;
      run_last_o      <= b_last;
      text_done_o     <= !in_data;
      replace_total_o <= b_total;
    end
  end

endmodule

/* design/stream_find_and_replace.sv */
// ----------------------------------------------------------------------------
// stream_find_and_replace: streaming byte find-and-replace
// Sliding-window pattern match with replacement, end-of-text flush and a
// saturating per-text replacement count.
// ----------------------------------------------------------------------------
//  channel   handshake          beat contents
//  -------   ----------------   -------------------------------------------
//  text in   push / full        in_byte_i, text_end_i
//  results   pop / empty        out_byte_o, byte_present_o, run_last_o,
//                               text_done_o, replace_total_o
//  config    cfg_we_i           cfg_idx_i selects, cfg_data_i (64b) written
//
//  One text beat is taken per cycle while the command queue has room; full
//  depends only on the queue count. The back end sends one result beat per
//  cycle, so a match with an 8-byte replacement makes 8 result beats (9 with
//  the end beat); meanwhile the 4-entry queue keeps taking beats until four
//  commands wait. pop low stalls the back end, and the input once the queue
//  fills. A beat's results pass the command queue, then the output register.
//  Reset clears the window fill, count, queue and output valid; config
//  registers reset to zero except pattern length, which resets to one.
// ----------------------------------------------------------------------------
module stream_find_and_replace import sfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // text in
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_byte_i,
  input  logic              text_end_i,
  // results
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte_o,
  output logic              byte_present_o,
  output logic              run_last_o,
  output logic              text_done_o,
  output logic [CountW-1:0] replace_total_o,
  // config
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i
);

  logic [63:0] pat_q, rep_q;
  logic [3:0]  plen_q, rlen_q;
  logic        clear;

  // config registers; a pattern length write also drops the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      plen_q <= 4'd1;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPatBytes: pat_q  <= cfg_data_i;
        CfgPatLen:   plen_q <= cfg_data_i[3:0];
        CfgRepBytes: rep_q  <= cfg_data_i;
        CfgRepLen:   rlen_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign clear = cfg_we_i && (cfg_idx_i == CfgPatLen);

  logic accept, cmd_push, cmd_valid, cmd_pop;
  cmd_t cmd, head;

  assign accept = push && !full;

  sfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .text_end_i  (text_end_i),
    .clear_i     (clear),
    .pat_bytes_i (pat_q),
    .pat_len_i   (eff_len(plen_q, 4'd1)),
    .rep_bytes_i (rep_q),
    .rep_len_i   (eff_len(rlen_q, 4'd0)),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd)
  );

  sfr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .head_o  (head)
  );

  sfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (cmd_valid),
    .head_i          (head),
    .head_pop_o      (cmd_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .out_byte_o      (out_byte_o),
    .byte_present_o  (byte_present_o),
    .run_last_o      (run_last_o),
    .text_done_o     (text_done_o),
    .replace_total_o (replace_total_o)
  );

  // front never writes a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !full) else $error("command pushed into full queue");

  // the final text beat always produces a command (end beat at least)
  a_end_makes_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && text_end_i) |-> cmd_push) else $error("end beat lost");

  // end result carries no text and closes its run
  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && text_done_o) |-> (!byte_present_o && run_last_o))
    else $error("malformed end beat");

  // queue pops only while it holds a command
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop from empty command queue");

endmodule

/* bench/stream_find_and_replace_tb.sv */
// ----------------------------------------------------------------------------
// stream_find_and_replace_tb: self-checking bench for stream find-and-replace
// Streams byte texts through the block under several pattern and
// replacement settings and checks every result beat against a
// cycle-independent predictor of the window, match and flush behavior.
// ----------------------------------------------------------------------------
module stream_find_and_replace_tb;
  import sfr_pkg::*;

  // cycles to let an in-flight text beat that makes no result settle
  localparam int SettleCycles = 8;
  // cap on printed mismatch lines; all are still counted
  localparam int MaxPrinted   = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_present;
    logic              run_last;
    logic              text_done;
    logic [CountW-1:0] total;
  } result_beat_t;

  // DUT signals
  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              push       = 1'b0;
  logic              full;
  logic [7:0]        in_byte_i  = 8'h00;
  logic              text_end_i = 1'b0;
  logic              empty;
  logic              pop        = 1'b0;
  logic [7:0]        out_byte_o;
  logic              byte_present_o;
  logic              run_last_o;
  logic              text_done_o;
  logic [CountW-1:0] replace_total_o;
  logic              cfg_we_i   = 1'b0;
  logic [1:0]        cfg_idx_i  = CfgPatBytes;
  logic [63:0]       cfg_data_i = '0;

  // predictor copy of the registers and the window
  logic [63:0]       pat_bytes;
  logic [3:0]        pat_len;
  logic [63:0]       rep_bytes;
  logic [3:0]        rep_len;
  logic [7:0]        win [MaxLen];
  int                fill;
  logic [CountW-1:0] match_cnt;

  text_beat_t   pending_text [$];   // text beats not yet offered
  result_beat_t expected_beats [$]; // predicted result beats, oldest first
  int           errors = 0;
  bit           calm   = 1'b0;      // no idling on either side while set

  stream_find_and_replace uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte_i),
    .text_end_i      (text_end_i),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .byte_present_o  (byte_present_o),
    .run_last_o      (run_last_o),
    .text_done_o     (text_done_o),
    .replace_total_o (replace_total_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MaxPrinted) $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  // length register as the block uses it: clamped to [minv, MaxLen]
  function automatic int clamp_len(input logic [3:0] v, input int minv);
    int n;
    n = int'(v);
    if (n < minv) n = minv;
    if (n > MaxLen) n = MaxLen;
    return n;
  endfunction

  function automatic result_beat_t text_result(input logic [7:0] b);
    result_beat_t r;
    r = '0;
    r.out_byte     = b;
    r.byte_present = 1'b1;
    return r;
  endfunction

  // Predict the result beats caused by one accepted text beat.
  task automatic predict_text_byte(input logic [7:0] b, input logic last);
    result_beat_t run [$];
    result_beat_t r;
    int           plen;
    int           rlen;
    logic         same;
    plen = clamp_len(pat_len, 1);
    rlen = clamp_len(rep_len, 0);
    if (fill >= plen) fill = 0;
    win[fill] = b;
    fill++;
    if (fill == plen) begin
      same = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (win[i] != pat_bytes[8*i +: 8]) same = 1'b0;
      end
      if (same) begin
        // match: replacement goes out, window restarts, no overlap
        for (int i = 0; i < rlen; i++) run.push_back(text_result(rep_bytes[8*i +: 8]));
        fill = 0;
        if (match_cnt != CountMax) match_cnt++;
      end else begin
        // no match: oldest byte leaves, window slides by one
        run.push_back(text_result(win[0]));
        for (int i = 0; i < MaxLen - 1; i++) win[i] = win[i+1];
        fill--;
      end
    end
    if (last) begin
      // flush what is left, then the end beat with the count
      for (int i = 0; i < fill; i++) run.push_back(text_result(win[i]));
      fill = 0;
      r = '0;
      r.text_done = 1'b1;
      r.total     = match_cnt;
      run.push_back(r);
      match_cnt = '0;
    end
    if (run.size() > 0) begin
      r = run.pop_back();
      r.run_last = 1'b1;
      run.push_back(r);
    end
    foreach (run[k]) expected_beats.push_back(run[k]);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued text beats, idles at random. A beat is taken at an
  // edge with push high and full low; the predictor runs on that edge with
  // the values that were on the ports.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : text_driver
    text_beat_t nxt;
    bit         taken;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      if (taken) predict_text_byte(in_byte_i, text_end_i);
      if (push && !taken) begin
        // hold the beat until it is taken
      end else if (pending_text.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
        nxt = pending_text.pop_front();
        in_byte_i  <= nxt.data;
        text_end_i <= nxt.last;
        push       <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pops at random and checks every taken result beat field by
  // field against the oldest expected beat.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    result_beat_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          if (out_byte_o !== want.out_byte)
            report_mismatch($sformatf("out_byte got %h want %h", out_byte_o, want.out_byte));
          if (byte_present_o !== want.byte_present)
            report_mismatch($sformatf("byte_present got %b want %b",
                                      byte_present_o, want.byte_present));
          if (run_last_o !== want.run_last)
            report_mismatch($sformatf("run_last got %b want %b", run_last_o, want.run_last));
          if (text_done_o !== want.text_done)
            report_mismatch($sformatf("text_done got %b want %b", text_done_o, want.text_done));
          if (replace_total_o !== want.total)
            report_mismatch($sformatf("replace_total got %0d want %0d",
                                      replace_total_o, want.total));
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // Wait until every queued beat is taken and every expected beat has come,
  // then let a beat with no result drain through the pipeline.
  task automatic wait_quiet();
    @(negedge clk_i);
    while (pending_text.size() != 0 || push || expected_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgPatBytes: pat_bytes = data;
      CfgPatLen: begin
        // a new pattern length drops whatever the window holds
        pat_len = data[3:0];
        fill    = 0;
      end
      CfgRepBytes: rep_bytes = data;
      CfgRepLen:   rep_len   = data[3:0];
      default: ;
    endcase
  endtask

  // Reprogram all four registers once the block is quiet. Junk rides in the
  // upper bits of the length writes; only the low nibble counts.
  task automatic set_regs(input logic [63:0] pb, input logic [3:0] pl,
                          input logic [63:0] rb, input logic [3:0] rl);
    logic [63:0] junk;
    wait_quiet();
    junk = {$urandom, $urandom};
    write_reg(CfgPatBytes, pb);
    write_reg(CfgPatLen, {junk[63:4], pl});
    write_reg(CfgRepBytes, rb);
    junk = {$urandom, $urandom};
    write_reg(CfgRepLen, {junk[63:4], rl});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    text_beat_t t;
    t.data = b;
    t.last = last;
    pending_text.push_back(t);
  endtask

  task automatic queue_string(input string s, input bit closes);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], closes && (i == s.len() - 1));
  endtask

  // Random text built mostly from copies of the pattern (some with a broken
  // last byte) and pattern bytes, with some fully random noise.
  task automatic random_text(input int n_items, input bit closes);
    int         made;
    int         plen;
    int         pick;
    logic [7:0] b;
    logic       last;
    plen = clamp_len(pat_len, 1);
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        for (int k = 0; k < plen && made < n_items; k++) begin
          b = pat_bytes[8*k +: 8];
          if (k == plen - 1 && $urandom_range(0, 3) == 0) b = 8'($urandom);
          made++;
          last = (closes && made == n_items) || ($urandom_range(0, 29) == 0);
          queue_byte(b, last);
        end
      end else begin
        if (pick < 85) b = pat_bytes[8*$urandom_range(0, plen - 1) +: 8];
        else           b = 8'($urandom);
        made++;
        last = (closes && made == n_items) || ($urandom_range(0, 24) == 0);
        queue_byte(b, last);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [63:0] r64;
    logic [3:0]  pl;
    logic [3:0]  rl;

    pat_bytes = '0;
    pat_len   = 4'd1;
    rep_bytes = '0;
    rep_len   = 4'd0;
    foreach (win[i]) win[i] = 8'h00;
    fill      = 0;
    match_cnt = '0;

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // slide, back-to-back matches, flush of a partial window at the end;
    // junk above the used pattern and replacement bytes must be ignored
    r64 = {$urandom, $urandom};
    set_regs({r64[63:24], "cba"}, 4'd3, {r64[31:0], r64[47:32], "YX"}, 4'd2);
    queue_string("xabcabcab", 1'b1);

    // longest pattern and replacement, lengths written above the maximum;
    // a match on the last byte gives the largest burst of beats
    r64 = {$urandom, $urandom};
    set_regs({64{1'b1}}, 4'd15, r64, 4'd15);
    queue_byte(8'h00, 1'b0);
    for (int i = 0; i < 8; i++) queue_byte(8'hFF, i == 7);

    // pattern length zero acts as one; zero-length replacement deletes
    r64 = {$urandom, $urandom};
    set_regs({r64[63:8], 8'h00}, 4'd0, {$urandom, $urandom}, 4'd0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b1);

    // leftmost match, no overlap; text left open so the next length write
    // drops the held bytes
    set_regs({40'h0, "aba"}, 4'd3, {$urandom, $urandom}, 4'd9);
    queue_string("ababa", 1'b0);

    // random phases; the drain before each setting also holds the sender
    // off until every expected beat is in
    for (int c = 0; c < 6; c++) begin
      case (c)
        0: begin pl = 4'd8; rl = 4'd8; end
        1: begin pl = 4'd1; rl = 4'd0; end
        default: begin
          pl = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 3));
          rl = 4'($urandom_range(0, 15));
        end
      endcase
      set_regs({$urandom, $urandom}, pl, {$urandom, $urandom}, rl);
      calm = (c == 2);
      random_text(40, $urandom_range(0, 1) == 1 || c == 5);
      wait_quiet();
      calm = 1'b0;
    end

    wait_quiet();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
